@@ src/srts_pkg.sv @@
// Package for the secure routing timer block: request and response types,
// event and verdict codes, register indexes, controller states and constants.
// Used by secure_routing_timer_sync; has no dependencies of its own.
package srts_pkg;

   localparam int TIMER_BITS = 48;

   localparam logic [2:0] OP_TICK        = 3'd0;
   localparam logic [2:0] OP_NOTIFY_RX   = 3'd1;
   localparam logic [2:0] OP_WRAPPER_RX  = 3'd2;
   localparam logic [2:0] OP_WRAPPER_TX  = 3'd3;
   localparam logic [2:0] OP_BEGIN_SYNC  = 3'd4;
   localparam logic [2:0] OP_CLEAR       = 3'd5;

   localparam logic [2:0] VERDICT_NONE     = 3'd0;
   localparam logic [2:0] VERDICT_ACCEPTED = 3'd1;
   localparam logic [2:0] VERDICT_DUP      = 3'd2;
   localparam logic [2:0] VERDICT_UNSYNC   = 3'd3;
   localparam logic [2:0] VERDICT_OUTDATED = 3'd4;

   localparam logic [1:0] REG_OWN_SERIAL     = 2'd0;
   localparam logic [1:0] REG_LATENCY_TOL    = 2'd1;
   localparam logic [1:0] REG_KEEPER_UPD_MIN = 2'd2;
   localparam logic [1:0] REG_KEEPER_PER_MIN = 2'd3;

   localparam logic [15:0] LATENCY_TOL_RESET    = 16'd1000;
   localparam logic [15:0] KEEPER_UPD_MIN_RESET = 16'd100;
   localparam logic [15:0] KEEPER_PER_MIN_RESET = 16'd10000;

   localparam logic [16:0] RECIP_TEN       = 17'd52429;
   localparam int          RECIP_TEN_SHIFT = 19;
   localparam logic [4:0]  DIV_LAST        = 5'd31;

   localparam logic signed [50:0] TIMER_MAX_S = 51'sd281474976710655;
   localparam logic signed [49:0] OFS_MAX     = 50'sh1FFFFFFFFFFFF;
   localparam logic signed [49:0] OFS_MIN     = 50'sh2000000000000;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [47:0] now_ms;
      logic [47:0] frame_serial;
      logic [15:0] frame_tag;
      logic [47:0] frame_timer;
      logic [31:0] random_draw;
      logic [15:0] entropy_tag;
      logic        random_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        notify_valid;
      logic [47:0] notify_serial;
      logic [15:0] notify_tag;
      logic [47:0] timer_out;
      logic        deadline_valid;
      logic [48:0] next_deadline;
      logic        is_synchronised;
      logic        is_timekeeper;
   } rsp_type;

   typedef struct packed {
      logic [47:0] serial;
      logic [15:0] tag;
      logic [47:0] timer;
   } cache_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOCAL,
      ST_TICK_SYNC,
      ST_TICK_NOTIFY,
      ST_NOTIFY_RX,
      ST_WR_ADDR,
      ST_WR_CMP,
      ST_WR_DECIDE,
      ST_OUTGOING,
      ST_BEGIN_SYNC,
      ST_CLEAR,
      ST_SCH_SETUP,
      ST_SCH_DIV,
      ST_SCH_DONE,
      ST_RESULT
   } state_type;

endpackage

@@ src/srts_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the duplicate cache entries; has no dependencies.
module srts_ram #(
   parameter int WIDTH = 112,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/secure_routing_timer_sync.sv @@
// Secure routing timer: timer offset, duplicate cache and notify scheduling.
// A wrapper compares each cached entry in turn; a notify schedule with entropy runs a bitwise
// remainder division of the random draw, else takes the lower bound; a tick may schedule twice.
// Throughput: one request at a time; a new request is taken once the last has finished.
// Reset clears all timer state, presets registers; cache contents stay, fill count gates them.
// Depends on srts_pkg and srts_ram.
module secure_routing_timer_sync #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srts_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   import srts_pkg::*;

   localparam int IDX_W  = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
   localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);
   localparam int ENTRY_W = $bits(cache_entry_type);

   state_type state_ff, state_in, ret_ff, ret_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [47:0] own_serial_ff, own_serial_in;
   logic [15:0] lat_ff, lat_in, kupd_ff, kupd_in, kper_ff, kper_in;
   logic [12:0] sl_ff;

   logic signed [49:0] offset_ff, offset_in;
   logic synced_ff, synced_in, keeper_ff, keeper_in;
   logic sync_pend_ff, sync_pend_in, upd_pend_ff, upd_pend_in, ntf_pend_ff, ntf_pend_in;
   logic [15:0] sync_tag_ff, sync_tag_in, upd_tag_ff, upd_tag_in;
   logic [48:0] sync_dl_ff, sync_dl_in, ntf_dl_ff, ntf_dl_in;
   logic [47:0] upd_serial_ff, upd_serial_in;
   logic [IDX_W-1:0]  wpos_ff, wpos_in;
   logic [FILL_W-1:0] fill_ff, fill_in, idx_ff, idx_in;
   logic [15:0] fallback_ff, fallback_in;

   logic [47:0] local_ff, local_in;
   logic        seen_ff, seen_in;
   logic        sch_upd_ff, sch_upd_in;
   logic [17:0] lo_ff, lo_in;
   logic [16:0] dvsr_ff, dvsr_in, rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [2:0]  verdict_ff, verdict_in;
   logic        nvalid_ff, nvalid_in;
   logic [47:0] nser_ff, nser_in;
   logic [15:0] ntag_ff, ntag_in;

   logic                ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr;
   cache_entry_type     ram_wr_entry, ram_rd_entry;
   logic [ENTRY_W-1:0]  ram_rd_data;

   logic [32:0] sl_prod;
   logic [47:0] timer_now;
   logic signed [50:0] rx_s, local_s, sl_s, lat_s, adv_sum, rx_off;
   logic signed [49:0] adv_sat;
   logic rx_gt_sl, rx_le_lat, rx_gt_local;
   logic [15:0] tag_draw, fallback_next;
   logic [16:0] sl_m, sl_10;
   logic [17:0] kmax;
   logic [17:0] div_shift;
   logic [18:0] sync_wait;
   logic [48:0] now49;
   logic cfg_wr;
   logic [48:0] dl_sel;

   srts_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_ENTRIES)) u_cache (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign ram_rd_entry = cache_entry_type'(ram_rd_data);
   assign ram_wr_entry = '{serial: req_ff.frame_serial, tag: req_ff.frame_tag,
                           timer: req_ff.frame_timer};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;

   always_comb begin
      case (paddr[4:3])
         REG_OWN_SERIAL:     prdata = {16'd0, own_serial_ff};
         REG_LATENCY_TOL:    prdata = {48'd0, lat_ff};
         REG_KEEPER_UPD_MIN: prdata = {48'd0, kupd_ff};
         REG_KEEPER_PER_MIN: prdata = {48'd0, kper_ff};
         default:            prdata = 64'd0;
      endcase
   end

   assign sl_prod = ({1'b0, lat_ff} + 17'd5) * {16'd0, RECIP_TEN};

   always_comb begin
      logic signed [50:0] sum;
      sum = $signed({3'b000, req_ff.now_ms}) + 51'(offset_ff);
      if (sum < 0) begin
         timer_now = 48'd0;
      end else if (sum > TIMER_MAX_S) begin
         timer_now = TIMER_MAX_S[47:0];
      end else begin
         timer_now = sum[47:0];
      end
   end

   assign now49       = {1'b0, req_ff.now_ms};
   assign rx_s        = $signed({3'b000, req_ff.frame_timer});
   assign local_s     = $signed({3'b000, local_ff});
   assign sl_s        = $signed({38'd0, sl_ff});
   assign lat_s       = $signed({35'd0, lat_ff});
   assign rx_gt_sl    = rx_s > (local_s - sl_s);
   assign rx_le_lat   = rx_s <= (local_s - lat_s);
   assign rx_gt_local = rx_s > local_s;
   assign adv_sum     = 51'(offset_ff) + (rx_s - local_s);
   assign adv_sat     = (adv_sum[50] != adv_sum[49]) ? (adv_sum[50] ? OFS_MIN : OFS_MAX)
                                                     : adv_sum[49:0];
   assign rx_off      = rx_s - $signed({3'b000, req_ff.now_ms});

   assign fallback_next = req_ff.random_ok ? fallback_ff : fallback_ff + 16'd1;
   assign tag_draw      = req_ff.random_ok ? req_ff.entropy_tag : fallback_ff + 16'd1;

   assign sl_m  = sch_upd_ff ? {4'd0, sl_ff} : ({4'd0, sl_ff} + {3'd0, sl_ff, 1'b0});
   assign sl_10 = {1'b0, sl_ff, 3'b000} + {3'd0, sl_ff, 1'b0};
   assign kmax  = {2'd0, (sch_upd_ff ? kupd_ff : kper_ff)} + {1'b0, sl_m};
   assign div_shift = {rem_ff, req_ff.random_draw[DIV_LAST - cnt_ff]};
   assign sync_wait = {3'd0, kupd_ff} + {3'd0, sl_ff, 3'b000} + {4'd0, sl_ff, 2'b00}
                      + {2'd0, lat_ff, 1'b0};

   always_comb begin
      dl_sel = 49'd0;
      if (ntf_pend_ff) begin
         dl_sel = ntf_dl_ff;
      end
      if (sync_pend_ff && (!ntf_pend_ff || sync_dl_ff < ntf_dl_ff)) begin
         dl_sel = sync_dl_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      req_in        = req_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      own_serial_in = own_serial_ff;
      lat_in        = lat_ff;
      kupd_in       = kupd_ff;
      kper_in       = kper_ff;
      offset_in     = offset_ff;
      synced_in     = synced_ff;
      keeper_in     = keeper_ff;
      sync_pend_in  = sync_pend_ff;
      upd_pend_in   = upd_pend_ff;
      ntf_pend_in   = ntf_pend_ff;
      sync_tag_in   = sync_tag_ff;
      upd_tag_in    = upd_tag_ff;
      sync_dl_in    = sync_dl_ff;
      ntf_dl_in     = ntf_dl_ff;
      upd_serial_in = upd_serial_ff;
      wpos_in       = wpos_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      fallback_in   = fallback_ff;
      local_in      = local_ff;
      seen_in       = seen_ff;
      sch_upd_in    = sch_upd_ff;
      lo_in         = lo_ff;
      dvsr_in       = dvsr_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      verdict_in    = verdict_ff;
      nvalid_in     = nvalid_ff;
      nser_in       = nser_ff;
      ntag_in       = ntag_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wpos_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff[IDX_W-1:0];

      if (cfg_wr) begin
         case (paddr[4:3])
            REG_OWN_SERIAL:     own_serial_in = pwdata[47:0];
            REG_LATENCY_TOL:    lat_in        = pwdata[15:0];
            REG_KEEPER_UPD_MIN: kupd_in       = pwdata[15:0];
            REG_KEEPER_PER_MIN: kper_in       = pwdata[15:0];
            default:            own_serial_in = own_serial_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               verdict_in = VERDICT_NONE;
               nvalid_in  = 1'b0;
               nser_in    = 48'd0;
               ntag_in    = 16'd0;
               state_in   = ST_LOCAL;
            end
         end
         ST_LOCAL: begin
            local_in = timer_now;
            idx_in   = '0;
            seen_in  = 1'b0;
            case (req_ff.opcode)
               OP_TICK:       state_in = ST_TICK_SYNC;
               OP_NOTIFY_RX:  state_in = ST_NOTIFY_RX;
               OP_WRAPPER_RX: state_in = (fill_ff == '0) ? ST_WR_DECIDE : ST_WR_ADDR;
               OP_WRAPPER_TX: state_in = ST_OUTGOING;
               OP_BEGIN_SYNC: state_in = ST_BEGIN_SYNC;
               OP_CLEAR:      state_in = ST_CLEAR;
               default:       state_in = ST_RESULT;
            endcase
         end
         ST_TICK_SYNC: begin
            state_in = ST_TICK_NOTIFY;
            if (sync_pend_ff && now49 >= sync_dl_ff) begin
               keeper_in    = 1'b1;
               sync_pend_in = 1'b0;
               sync_tag_in  = 16'd0;
               synced_in    = 1'b1;
               sch_upd_in   = 1'b0;
               ret_in       = ST_TICK_NOTIFY;
               state_in     = ST_SCH_SETUP;
            end
         end
         ST_TICK_NOTIFY: begin
            state_in = ST_RESULT;
            if (ntf_pend_ff && now49 >= ntf_dl_ff) begin
               nvalid_in = 1'b1;
               if (upd_pend_ff) begin
                  nser_in = upd_serial_ff;
                  ntag_in = upd_tag_ff;
               end else begin
                  nser_in     = own_serial_ff;
                  ntag_in     = tag_draw;
                  fallback_in = fallback_next;
               end
               keeper_in  = 1'b1;
               sch_upd_in = 1'b0;
               ret_in     = ST_RESULT;
               state_in   = ST_SCH_SETUP;
            end
         end
         ST_NOTIFY_RX: begin
            state_in   = ST_RESULT;
            ret_in     = ST_RESULT;
            sch_upd_in = 1'b0;
            if (sync_pend_ff && req_ff.frame_serial == own_serial_ff
                && req_ff.frame_tag == sync_tag_ff) begin
               offset_in    = rx_off[49:0];
               sync_pend_in = 1'b0;
               sync_tag_in  = 16'd0;
               synced_in    = 1'b1;
               state_in     = ST_SCH_SETUP;
            end else if (rx_gt_sl) begin
               if (rx_gt_local) begin
                  offset_in = adv_sat;
               end
               keeper_in = 1'b0;
               state_in  = ST_SCH_SETUP;
            end else if (rx_le_lat && !upd_pend_ff) begin
               sch_upd_in = 1'b1;
               state_in   = ST_SCH_SETUP;
            end
         end
         ST_WR_ADDR: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WR_CMP;
         end
         ST_WR_CMP: begin
            if (ram_rd_entry == ram_wr_entry) begin
               seen_in = 1'b1;
            end
            idx_in   = idx_ff + FILL_W'(1);
            state_in = (idx_in == fill_ff) ? ST_WR_DECIDE : ST_WR_ADDR;
         end
         ST_WR_DECIDE: begin
            state_in   = ST_RESULT;
            ret_in     = ST_RESULT;
            sch_upd_in = 1'b0;
            if (!synced_ff) begin
               verdict_in = VERDICT_UNSYNC;
            end else if (seen_ff) begin
               verdict_in = VERDICT_DUP;
            end else if (rx_le_lat) begin
               verdict_in = VERDICT_OUTDATED;
               if (!upd_pend_ff) begin
                  sch_upd_in = 1'b1;
                  state_in   = ST_SCH_SETUP;
               end
            end else begin
               verdict_in = VERDICT_ACCEPTED;
               if (rx_gt_sl && !upd_pend_ff) begin
                  state_in = ST_SCH_SETUP;
               end
               if (rx_gt_local) begin
                  offset_in = adv_sat;
               end
               ram_wr_en = 1'b1;
               wpos_in   = (wpos_ff == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : wpos_ff + IDX_W'(1);
               if (fill_ff != FILL_W'(CACHE_ENTRIES)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
         end
         ST_OUTGOING: begin
            state_in   = upd_pend_ff ? ST_RESULT : ST_SCH_SETUP;
            ret_in     = ST_RESULT;
            sch_upd_in = 1'b0;
         end
         ST_BEGIN_SYNC: begin
            synced_in    = 1'b0;
            sync_tag_in  = tag_draw;
            fallback_in  = fallback_next;
            sync_pend_in = 1'b1;
            sync_dl_in   = now49 + {30'd0, sync_wait};
            nvalid_in    = 1'b1;
            nser_in      = own_serial_ff;
            ntag_in      = tag_draw;
            state_in     = ST_RESULT;
         end
         ST_CLEAR: begin
            offset_in     = '0;
            synced_in     = 1'b0;
            keeper_in     = 1'b0;
            sync_pend_in  = 1'b0;
            upd_pend_in   = 1'b0;
            ntf_pend_in   = 1'b0;
            sync_tag_in   = 16'd0;
            sync_dl_in    = 49'd0;
            upd_serial_in = 48'd0;
            upd_tag_in    = 16'd0;
            ntf_dl_in     = 49'd0;
            wpos_in       = '0;
            fill_in       = '0;
            state_in      = ST_RESULT;
         end
         ST_SCH_SETUP: begin
            if (keeper_ff) begin
               lo_in   = {2'd0, (sch_upd_ff ? kupd_ff : kper_ff)};
               dvsr_in = sl_m + 17'd1;
            end else begin
               lo_in   = kmax + {5'd0, sl_ff};
               dvsr_in = sl_10 + 17'd1;
            end
            rem_in   = 17'd0;
            cnt_in   = 5'd0;
            state_in = req_ff.random_ok ? ST_SCH_DIV : ST_SCH_DONE;
         end
         ST_SCH_DIV: begin
            if (div_shift >= {1'b0, dvsr_ff}) begin
               rem_in = 17'(div_shift - {1'b0, dvsr_ff});
            end else begin
               rem_in = div_shift[16:0];
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SCH_DONE;
            end
         end
         ST_SCH_DONE: begin
            upd_pend_in   = sch_upd_ff;
            upd_serial_in = sch_upd_ff ? req_ff.frame_serial : 48'd0;
            upd_tag_in    = sch_upd_ff ? req_ff.frame_tag : 16'd0;
            ntf_pend_in   = 1'b1;
            ntf_dl_in     = now49 + {31'd0, lo_ff} + {32'd0, rem_ff};
            state_in      = ret_ff;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.verdict         = verdict_ff;
               rsp_data_in.notify_valid    = nvalid_ff;
               rsp_data_in.notify_serial   = nser_ff;
               rsp_data_in.notify_tag      = ntag_ff;
               rsp_data_in.timer_out       = timer_now;
               rsp_data_in.deadline_valid  = ntf_pend_ff || sync_pend_ff;
               rsp_data_in.next_deadline   = dl_sel;
               rsp_data_in.is_synchronised = synced_ff;
               rsp_data_in.is_timekeeper   = keeper_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         own_serial_ff <= 48'd0;
         lat_ff        <= LATENCY_TOL_RESET;
         kupd_ff       <= KEEPER_UPD_MIN_RESET;
         kper_ff       <= KEEPER_PER_MIN_RESET;
         offset_ff     <= '0;
         synced_ff     <= 1'b0;
         keeper_ff     <= 1'b0;
         sync_pend_ff  <= 1'b0;
         upd_pend_ff   <= 1'b0;
         ntf_pend_ff   <= 1'b0;
         sync_tag_ff   <= 16'd0;
         upd_tag_ff    <= 16'd0;
         sync_dl_ff    <= 49'd0;
         ntf_dl_ff     <= 49'd0;
         upd_serial_ff <= 48'd0;
         wpos_ff       <= '0;
         fill_ff       <= '0;
         fallback_ff   <= 16'd0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         rsp_valid_ff  <= rsp_valid_in;
         own_serial_ff <= own_serial_in;
         lat_ff        <= lat_in;
         kupd_ff       <= kupd_in;
         kper_ff       <= kper_in;
         offset_ff     <= offset_in;
         synced_ff     <= synced_in;
         keeper_ff     <= keeper_in;
         sync_pend_ff  <= sync_pend_in;
         upd_pend_ff   <= upd_pend_in;
         ntf_pend_ff   <= ntf_pend_in;
         sync_tag_ff   <= sync_tag_in;
         upd_tag_ff    <= upd_tag_in;
         sync_dl_ff    <= sync_dl_in;
         ntf_dl_ff     <= ntf_dl_in;
         upd_serial_ff <= upd_serial_in;
         wpos_ff       <= wpos_in;
         fill_ff       <= fill_in;
         fallback_ff   <= fallback_in;
      end
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      sl_ff       <= sl_prod[RECIP_TEN_SHIFT+12:RECIP_TEN_SHIFT];
      local_ff    <= local_in;
      seen_ff     <= seen_in;
      idx_ff      <= idx_in;
      sch_upd_ff  <= sch_upd_in;
      lo_ff       <= lo_in;
      dvsr_ff     <= dvsr_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      verdict_ff  <= verdict_in;
      nvalid_ff   <= nvalid_in;
      nser_ff     <= nser_in;
      ntag_ff     <= ntag_in;
   end
endmodule

@@ test/tb_secure_routing_timer_sync.sv @@
// Testbench for secure_routing_timer_sync: a directed table, then random phases under
// several register settings; fixed rows are checked as given, the rest against an
// in-bench timer predictor. Depends on srts_pkg and on the block and its RAM under src.
module tb_secure_routing_timer_sync;
   import srts_pkg::*;

   localparam logic [2:0]  OP_SPARE_LO = 3'd6;
   localparam logic [2:0]  OP_SPARE_HI = 3'd7;
   localparam logic [48:0] DEADLINE_MAX = 49'h1FFFFFFFFFFFF;
   localparam longint      OFFSET_MAX = 64'sh1FFFFFFFFFFFF;
   localparam longint      TIMER_TOP = 64'shFFFFFFFFFFFF;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic psel, penable, pwrite, pready;
   logic [4:0] paddr;
   logic [63:0] pwdata, prdata;

   secure_routing_timer_sync u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type e;
   } table_row_type;

   // Register copies and timer state as the predictor sees them.
   logic [47:0] cfg_serial;
   logic [15:0] cfg_latency, cfg_upd_min, cfg_per_min;
   longint      offset;
   bit          synced, keeper, sync_pend, upd_pend, ntf_pend;
   logic [15:0] sync_tag, upd_tag, fallback_tag;
   logic [47:0] upd_serial;
   logic [48:0] sync_deadline, ntf_deadline;
   logic [47:0] seen_serial [32];
   logic [15:0] seen_tag [32];
   logic [47:0] seen_timer [32];
   int          seen_pos, seen_fill;

   rsp_type     expected_q[$];
   req_type     wrapper_log[$];
   int          burst_left;
   bit          failed;
   logic [47:0] now_cur;
   int          stall_mode, stall_left;

   function automatic longint sync_latency();
      return (longint'(cfg_latency) + 5) / 10;
   endfunction

   function automatic longint timer_at(logic [47:0] t);
      longint v;
      v = longint'(t) + offset;
      if (v < 0) return 0;
      if (v > TIMER_TOP) return TIMER_TOP;
      return v;
   endfunction

   function automatic longint clamp_offset(longint v);
      if (v > OFFSET_MAX) return OFFSET_MAX;
      if (v < -OFFSET_MAX - 1) return -OFFSET_MAX - 1;
      return v;
   endfunction

   function automatic logic [15:0] take_tag(req_type r);
      if (r.random_ok) return r.entropy_tag;
      fallback_tag = fallback_tag + 16'd1;
      return fallback_tag;
   endfunction

   function automatic void plan_notify(bit upd, logic [47:0] ser, logic [15:0] tg, req_type r);
      longint sl, kmin, kmax, lo, hi;
      logic [63:0] dly, sum;
      sl = sync_latency();
      kmin = upd ? longint'(cfg_upd_min) : longint'(cfg_per_min);
      kmax = kmin + (upd ? 1 : 3) * sl;
      lo = kmin;
      hi = kmax;
      if (!keeper) begin
         lo = kmax + sl;
         hi = kmax + 11 * sl;
      end
      dly = r.random_ok ? 64'(lo) + (64'(r.random_draw) % 64'(hi - lo + 1)) : 64'(lo);
      sum = 64'(r.now_ms) + dly;
      upd_pend = upd;
      upd_serial = upd ? ser : 48'd0;
      upd_tag = upd ? tg : 16'd0;
      ntf_pend = 1;
      ntf_deadline = (sum > 64'(DEADLINE_MAX)) ? DEADLINE_MAX : sum[48:0];
   endfunction

   function automatic void finish_sync(req_type r);
      sync_pend = 0;
      sync_tag = 0;
      synced = 1;
      plan_notify(0, 48'd0, 16'd0, r);
   endfunction

   function automatic void advance_timer(longint here, longint rx);
      if (rx > here) offset = clamp_offset(offset + (rx - here));
   endfunction

   function automatic rsp_type predict_timer(req_type r);
      rsp_type o;
      longint  sl, lat, here, rx;
      bit      seen;
      logic [48:0] dl;
      o = '0;
      sl = sync_latency();
      lat = longint'(cfg_latency);
      rx = longint'(r.frame_timer);
      case (r.opcode)
         OP_TICK: begin
            if (sync_pend && {1'b0, r.now_ms} >= sync_deadline) begin
               keeper = 1;
               finish_sync(r);
            end
            if (ntf_pend && {1'b0, r.now_ms} >= ntf_deadline) begin
               if (upd_pend) begin
                  o.notify_serial = upd_serial;
                  o.notify_tag = upd_tag;
               end else begin
                  o.notify_serial = cfg_serial;
                  o.notify_tag = take_tag(r);
               end
               o.notify_valid = 1;
               keeper = 1;
               plan_notify(0, 48'd0, 16'd0, r);
            end
         end
         OP_NOTIFY_RX: begin
            if (sync_pend && r.frame_serial == cfg_serial && r.frame_tag == sync_tag) begin
               offset = clamp_offset(rx - longint'(r.now_ms));
               finish_sync(r);
            end else begin
               here = timer_at(r.now_ms);
               if (rx > here - sl) begin
                  advance_timer(here, rx);
                  keeper = 0;
                  plan_notify(0, 48'd0, 16'd0, r);
               end else if (rx <= here - lat && !upd_pend) begin
                  plan_notify(1, r.frame_serial, r.frame_tag, r);
               end
            end
         end
         OP_WRAPPER_RX: begin
            seen = 0;
            for (int i = 0; i < seen_fill; i++)
               if (seen_serial[i] == r.frame_serial && seen_tag[i] == r.frame_tag &&
                   seen_timer[i] == r.frame_timer) seen = 1;
            if (!synced) begin
               o.verdict = VERDICT_UNSYNC;
            end else if (seen) begin
               o.verdict = VERDICT_DUP;
            end else begin
               here = timer_at(r.now_ms);
               if (rx <= here - lat) begin
                  if (!upd_pend) plan_notify(1, r.frame_serial, r.frame_tag, r);
                  o.verdict = VERDICT_OUTDATED;
               end else begin
                  if (rx > here - sl && !upd_pend) plan_notify(0, 48'd0, 16'd0, r);
                  advance_timer(here, rx);
                  seen_serial[seen_pos] = r.frame_serial;
                  seen_tag[seen_pos] = r.frame_tag;
                  seen_timer[seen_pos] = r.frame_timer;
                  seen_pos = (seen_pos + 1) % 32;
                  if (seen_fill < 32) seen_fill++;
                  o.verdict = VERDICT_ACCEPTED;
               end
            end
         end
         OP_WRAPPER_TX: begin
            if (!upd_pend) plan_notify(0, 48'd0, 16'd0, r);
         end
         OP_BEGIN_SYNC: begin
            synced = 0;
            sync_tag = take_tag(r);
            sync_pend = 1;
            sync_deadline = {1'b0, r.now_ms} + 49'(cfg_upd_min) + 49'(12 * sl) + 49'(2 * lat);
            o.notify_valid = 1;
            o.notify_serial = cfg_serial;
            o.notify_tag = sync_tag;
         end
         OP_CLEAR: begin
            offset = 0;
            {synced, keeper, sync_pend, upd_pend, ntf_pend} = '0;
            sync_tag = 0;
            sync_deadline = 0;
            upd_serial = 0;
            upd_tag = 0;
            ntf_deadline = 0;
            seen_pos = 0;
            seen_fill = 0;
         end
         default: ;
      endcase
      dl = 0;
      if (ntf_pend) dl = ntf_deadline;
      if (sync_pend && (!ntf_pend || sync_deadline < dl)) dl = sync_deadline;
      o.timer_out = 48'(timer_at(r.now_ms));
      o.deadline_valid = ntf_pend || sync_pend;
      o.next_deadline = o.deadline_valid ? dl : 49'd0;
      o.is_synchronised = synced;
      o.is_timekeeper = keeper;
      return o;
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [47:0] t, logic [47:0] fser,
                                        logic [15:0] ftag, logic [47:0] ftim,
                                        logic [31:0] draw, logic [15:0] rtag, bit ok);
      req_type r;
      r.opcode = op;
      r.now_ms = t;
      r.frame_serial = fser;
      r.frame_tag = ftag;
      r.frame_timer = ftim;
      r.random_draw = draw;
      r.entropy_tag = rtag;
      r.random_ok = ok;
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t: %s expected %h, got %h", $time, name, e, a);
         failed = 1;
      end
   endfunction

   task automatic send_request(req_type r, bit fixed, rsp_type e);
      rsp_type p;
      bit go;
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         go = !req_stall;
         @(posedge clock);
      end while (!go);
      p = predict_timer(r);
      expected_q.push_back(fixed ? e : p);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_OWN_SERIAL:     cfg_serial = val[47:0];
         REG_LATENCY_TOL:    cfg_latency = val[15:0];
         REG_KEEPER_UPD_MIN: cfg_upd_min = val[15:0];
         default:            cfg_per_min = val[15:0];
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   function automatic req_type random_request();
      req_type r;
      int pick;
      longint here, span, rx;
      logic [48:0] dl;
      r = make_req(OP_TICK, now_cur, 48'({$urandom, $urandom}), 16'($urandom),
                   48'({$urandom, $urandom}), $urandom, 16'($urandom),
                   $urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 2) now_cur = 48'({$urandom, $urandom});
      else now_cur = now_cur + $urandom_range(0, 2000);
      r.now_ms = now_cur;
      here = timer_at(now_cur);
      span = 2 * longint'(cfg_latency) + 3 * sync_latency() + 2;
      rx = here + longint'($urandom_range(0, 32'(2 * span))) - 3 * longint'(cfg_latency) / 2
           - 1;
      if (rx < 0) rx = 0;
      if (rx > TIMER_TOP) rx = TIMER_TOP;
      if ($urandom_range(0, 9) != 0) r.frame_timer = 48'(rx);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         dl = ntf_pend ? ntf_deadline : sync_deadline;
         if (sync_pend && sync_deadline < dl) dl = sync_deadline;
         if ((ntf_pend || sync_pend) && $urandom_range(0, 1) && dl < 49'h0FFFFFFFFF000) begin
            now_cur = dl[47:0] + $urandom_range(0, 50);
            r.now_ms = now_cur;
         end
      end else if (pick < 33) begin
         r.opcode = OP_BEGIN_SYNC;
      end else if (pick < 53) begin
         r.opcode = OP_NOTIFY_RX;
         if (sync_pend && $urandom_range(0, 2) != 0) begin
            r.frame_serial = cfg_serial;
            r.frame_tag = sync_tag;
         end
      end else if (pick < 85) begin
         r.opcode = OP_WRAPPER_RX;
         if (wrapper_log.size() > 0 && $urandom_range(0, 3) == 0)
            r = wrapper_log[$urandom_range(0, wrapper_log.size() - 1)];
         if ($urandom_range(0, 1)) r.frame_serial = cfg_serial ^ $urandom_range(0, 3);
         wrapper_log.push_back(r);
         if (wrapper_log.size() > 40) void'(wrapper_log.pop_front());
      end else if (pick < 95) begin
         r.opcode = OP_WRAPPER_TX;
      end else if (pick < 98) begin
         r.opcode = OP_CLEAR;
      end else begin
         r.opcode = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(64'd12 * 64'd3000000);
      $display("secure_routing_timer_sync: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         stall_mode <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 300);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= (stall_left % 16) < 5;
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
            failed = 1;
         end else begin
            e = expected_q.pop_front();
            check_field("verdict", e.verdict, rsp_data.verdict);
            check_field("notify_valid", e.notify_valid, rsp_data.notify_valid);
            check_field("notify_serial", e.notify_serial, rsp_data.notify_serial);
            check_field("notify_tag", e.notify_tag, rsp_data.notify_tag);
            check_field("timer_out", e.timer_out, rsp_data.timer_out);
            check_field("deadline_valid", e.deadline_valid, rsp_data.deadline_valid);
            check_field("next_deadline", e.next_deadline, rsp_data.next_deadline);
            check_field("is_synchronised", e.is_synchronised, rsp_data.is_synchronised);
            check_field("is_timekeeper", e.is_timekeeper, rsp_data.is_timekeeper);
         end
      end
   end

   initial begin
      table_row_type rows[$];
      table_row_type row;
      logic [63:0] phase_cfg [4][4];
      logic [47:0] m48;
      m48 = 48'hFFFFFFFFFFFF;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      failed = 0;
      burst_left = 0;
      now_cur = 0;
      cfg_serial = 0;
      cfg_latency = LATENCY_TOL_RESET;
      cfg_upd_min = KEEPER_UPD_MIN_RESET;
      cfg_per_min = KEEPER_PER_MIN_RESET;
      offset = 0;
      {synced, keeper, sync_pend, upd_pend, ntf_pend} = '0;
      {sync_tag, upd_tag, fallback_tag, upd_serial, sync_deadline, ntf_deadline} = '0;
      seen_pos = 0;
      seen_fill = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset nothing is pending and the timer follows the clock.
      row.fixed = 1;
      row.r = make_req(OP_TICK, 48'd0, 48'd0, 16'd0, 48'd0, 32'd0, 16'd0, 1'b0);
      row.e = '0;
      rows.push_back(row);
      row.r = make_req(OP_WRAPPER_RX, 48'd100, m48, 16'hFFFF, m48, '1, 16'hFFFF, 1'b1);
      row.e = '0;
      row.e.verdict = VERDICT_UNSYNC;
      row.e.timer_out = 48'd100;
      rows.push_back(row);
      row.r = make_req(OP_BEGIN_SYNC, 48'd1000, 48'd0, 16'd0, 48'd0, 32'd0, 16'hFFFF, 1'b1);
      row.e = '0;
      row.e.notify_valid = 1;
      row.e.notify_tag = 16'hFFFF;
      row.e.timer_out = 48'd1000;
      row.e.deadline_valid = 1;
      row.e.next_deadline = 49'd4300;
      rows.push_back(row);
      row.fixed = 0;
      row.r = make_req(OP_NOTIFY_RX, 48'd1100, 48'd0, 16'hFFFF, 48'd5000, '1, 16'h0, 1'b1);
      rows.push_back(row);
      row.r = make_req(OP_WRAPPER_RX, 48'd1200, m48, 16'hFFFF, 48'd5200, '0, 16'h0, 1'b1);
      rows.push_back(row);
      rows.push_back(row);
      row.r = make_req(OP_WRAPPER_RX, 48'd1300, 48'd7, 16'h0001, 48'd0, 32'h8000_0000,
                       16'h0, 1'b0);
      rows.push_back(row);
      row.r = make_req(OP_WRAPPER_TX, 48'd1400, 48'd0, 16'd0, 48'd0, 32'h1234, 16'h0, 1'b1);
      rows.push_back(row);
      row.r = make_req(OP_NOTIFY_RX, 48'd1500, 48'd3, 16'h0055, 48'd0, 32'h5, 16'h0, 1'b1);
      rows.push_back(row);
      row.r = make_req(OP_TICK, 48'd900000, 48'd0, 16'd0, 48'd0, 32'h77, 16'hAAAA, 1'b0);
      rows.push_back(row);
      row.r = make_req(OP_TICK, 48'd1900000, 48'd0, 16'd0, 48'd0, 32'h77, 16'h5555, 1'b0);
      rows.push_back(row);
      row.r = make_req(OP_SPARE_LO, 48'd2000000, m48, 16'hFFFF, m48, '1, 16'hFFFF, 1'b1);
      rows.push_back(row);
      row.r = make_req(OP_BEGIN_SYNC, 48'd2000000, 48'd0, 16'd0, 48'd0, 32'd0, 16'h1, 1'b0);
      rows.push_back(row);
      row.r = make_req(OP_TICK, m48, 48'd0, 16'd0, 48'd0, '1, 16'h0, 1'b1);
      rows.push_back(row);
      row.r = make_req(OP_NOTIFY_RX, m48, 48'h1, 16'h2, m48, '1, 16'h0, 1'b1);
      rows.push_back(row);
      row.r = make_req(OP_SPARE_HI, m48, 48'd0, 16'd0, 48'd0, 32'd0, 16'h0, 1'b0);
      rows.push_back(row);
      row.fixed = 1;
      row.r = make_req(OP_CLEAR, 48'd5, 48'd0, 16'd0, 48'd0, 32'd0, 16'h0, 1'b0);
      row.e = '0;
      row.e.timer_out = 48'd5;
      rows.push_back(row);
      foreach (rows[i]) send_request(rows[i].r, rows[i].fixed, rows[i].e);

      phase_cfg[0] = '{64'hFFFFFFFFFFFF, 64'd0, 64'd0, 64'd0};
      phase_cfg[1] = '{64'h123456789ABC, 64'd65535, 64'd65535, 64'd65535};
      phase_cfg[2] = '{{$urandom, $urandom} & 64'hFFFFFFFFFFFF, 64'(LATENCY_TOL_RESET),
                       64'(KEEPER_UPD_MIN_RESET), 64'(KEEPER_PER_MIN_RESET)};
      phase_cfg[3] = '{{$urandom, $urandom} & 64'hFFFFFFFFFFFF, 64'($urandom_range(0, 3000)),
                       64'($urandom_range(0, 500)), 64'($urandom_range(0, 20000))};
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         csr_write(REG_OWN_SERIAL, phase_cfg[ph][0]);
         csr_write(REG_LATENCY_TOL, phase_cfg[ph][1]);
         csr_write(REG_KEEPER_UPD_MIN, phase_cfg[ph][2]);
         csr_write(REG_KEEPER_PER_MIN, phase_cfg[ph][3]);
         @(posedge clock);
         for (int n = 0; n < 385; n++) send_request(random_request(), 0, '0);
      end
      wait_idle();
      if (!failed && expected_q.size() == 0) begin
         $display("secure_routing_timer_sync: match");
      end else begin
         $display("secure_routing_timer_sync: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/srts_pkg.sv
src/srts_ram.sv
src/secure_routing_timer_sync.sv
test/tb_secure_routing_timer_sync.sv
